[rtl/psoa_pkg.sv]
// shared types and constants of the multi-server offset aggregator
// no dependencies
package psoa_pkg;

   localparam int TS_W            = 64;
   localparam int DEF_MAX_SERVERS = 16;
   localparam int DEF_FAULT_LIMIT = 1;
   localparam int IDX_W           = 4;
   localparam int CNT_W           = 5;

   localparam logic [CNT_W-1:0] CNT_RESET = 5'd4;

   localparam logic KIND_SYNC = 1'b0;
   localparam logic KIND_RESP = 1'b1;
   localparam logic RES_REQ   = 1'b0;
   localparam logic RES_MEAS  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_R_RD,
      ST_R_SUM,
      ST_R_HALF,
      ST_A_I,
      ST_A_IWAIT,
      ST_A_J,
      ST_A_JWAIT,
      ST_A_SQ,
      ST_A_SCW,
      ST_A_INEXT,
      ST_P_INIT,
      ST_P_START,
      ST_P_SCAN,
      ST_P_CMP,
      ST_P_PICK,
      ST_P_PWAIT,
      ST_P_DIV,
      ST_P_END,
      ST_DONE
   } state_type;

   // partial product order of the square unit
   typedef enum logic [1:0] {
      SQ_LL,
      SQ_LH,
      SQ_HH
   } sq_step_type;

   typedef struct packed {
      logic start;
      logic clear;
   } sq_ctl_type;

endpackage

[rtl/ptp_multi_server_offset_aggregator_top.sv]
// Follower side of a two-way time exchange with up to MAX_SERVERS servers.
// A sync beat stores t1/t2/t3 for its server and is answered with a delay
// request. A delay-response beat reads the stored times, forms the down and
// up legs, then their sum and difference, and halves both into path delay
// and offset; when it closes a round with more than FAULT_LIMIT measured
// servers, a fault tolerant average of delay and of offset follows. Its time
// is set by the single shared 32x32 square-accumulate unit, run once per
// measured pair, the score memory sweep and the divide by FAULT_LIMIT+1. One
// beat is in work at a time, and a result that is not taken holds the next
// one back.
// Depends on psoa_pkg, psoa_ram, psoa_sqacc, psoa_cdiv.
module ptp_multi_server_offset_aggregator_top import psoa_pkg::*; #(
   parameter int MAX_SERVERS = DEF_MAX_SERVERS,
   parameter int FAULT_LIMIT = DEF_FAULT_LIMIT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CNT_W-1:0]       csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [IDX_W-1:0]       req_server_index,
   input  logic [TS_W-1:0]        req_remote_time,
   input  logic [TS_W-1:0]        req_arrival_time,
   input  logic [TS_W-1:0]        req_departure_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_result_kind,
   output logic [IDX_W-1:0]       rsp_server_out,
   output logic [TS_W-1:0]        rsp_request_send_time,
   output logic [TS_W-1:0]        rsp_request_echo_time,
   output logic signed [TS_W-1:0] rsp_path_delay,
   output logic signed [TS_W-1:0] rsp_clock_offset,
   output logic                   rsp_aggregate_valid,
   output logic signed [TS_W-1:0] rsp_aggregate_delay,
   output logic signed [TS_W-1:0] rsp_aggregate_offset
);

   localparam int IW = $clog2(MAX_SERVERS);
   localparam int CW = $clog2(MAX_SERVERS + 1);
   localparam int SW = 2 * TS_W + IW;
   localparam int KW = $clog2(FAULT_LIMIT + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SERVERS - 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       srv_cnt_ff, tally_ff, tally_in;
   logic [MAX_SERVERS-1:0] tv_ff, flag_ff, picked_ff;
   logic [CW-1:0]          meas_ff, meas_in;

   logic                   kind_ff;
   logic [IDX_W-1:0]       sidx_ff;
   logic [IW-1:0]          idx_ff, req_idx;
   logic [TS_W-1:0]        remote_ff, t2_ff, t3_ff;
   logic [TS_W-1:0]        down_ff, up_ff, sum_ff, dif_ff;
   logic [TS_W-1:0]        delay_ff, offset_ff, half_s, half_d;
   logic                   aggv_ff;
   logic [TS_W-1:0]        aggd_ff, aggo_ff, acc_sum_ff;
   logic                   sel_ff, round_go;

   logic [IW-1:0]          i_ff, j_ff, m_ff, best_ff;
   logic [KW-1:0]          k_ff;
   logic                   found_ff;
   logic [SW-1:0]          best_sc_ff;
   logic [TS_W-1:0]        a_ff;

   logic                   accept, in_range;
   logic                   ts_we, val_we, sc_we, div_start, div_done;
   logic [IW-1:0]          val_raddr;
   logic [TS_W-1:0]        t1_rd, t2_rd, t3_rd, t1m, t2m, t3m;
   logic [TS_W-1:0]        del_rd, off_rd, val_rd, mag, quot;
   logic [SW-1:0]          sc_rd, sq_acc;
   sq_ctl_type             sq_ctl;
   logic                   sq_busy;

   logic                   rsp_valid_ff;
   logic                   o_kind_ff, o_aggv_ff;
   logic [IDX_W-1:0]       o_srv_ff;
   logic [TS_W-1:0]        o_send_ff, o_echo_ff, o_del_ff, o_off_ff, o_aggd_ff, o_aggo_ff;

   assign req_idx  = IW'(req_server_index);
   assign in_range = 32'(req_server_index) < MAX_SERVERS;
   assign accept   = req_valid && req_ready;

   // timestamp stores; entries never written are masked to zero by the valid bits
   psoa_ram #(.WIDTH(TS_W), .DEPTH(MAX_SERVERS)) u_t1_ram (
      .clock(clock), .we(ts_we), .waddr(req_idx), .wdata(req_remote_time),
      .raddr(req_idx), .rdata(t1_rd));
   psoa_ram #(.WIDTH(TS_W), .DEPTH(MAX_SERVERS)) u_t2_ram (
      .clock(clock), .we(ts_we), .waddr(req_idx), .wdata(req_arrival_time),
      .raddr(req_idx), .rdata(t2_rd));
   psoa_ram #(.WIDTH(TS_W), .DEPTH(MAX_SERVERS)) u_t3_ram (
      .clock(clock), .we(ts_we), .waddr(req_idx), .wdata(req_departure_time),
      .raddr(req_idx), .rdata(t3_rd));

   psoa_ram #(.WIDTH(TS_W), .DEPTH(MAX_SERVERS)) u_del_ram (
      .clock(clock), .we(val_we), .waddr(idx_ff), .wdata(half_s),
      .raddr(val_raddr), .rdata(del_rd));
   psoa_ram #(.WIDTH(TS_W), .DEPTH(MAX_SERVERS)) u_off_ram (
      .clock(clock), .we(val_we), .waddr(idx_ff), .wdata(half_d),
      .raddr(val_raddr), .rdata(off_rd));

   psoa_ram #(.WIDTH(SW), .DEPTH(MAX_SERVERS)) u_score_ram (
      .clock(clock), .we(sc_we), .waddr(i_ff), .wdata(sq_acc),
      .raddr(m_ff), .rdata(sc_rd));

   psoa_sqacc #(.SCORE_W(SW)) u_sqacc (
      .clock(clock), .reset(reset), .ctl(sq_ctl), .mag(mag),
      .busy(sq_busy), .acc(sq_acc));

   psoa_cdiv #(.DIVISOR(FAULT_LIMIT + 1)) u_cdiv (
      .clock(clock), .reset(reset), .start(div_start), .value(val_rd),
      .done(div_done), .quot(quot));

   assign t1m    = tv_ff[idx_ff] ? t1_rd : '0;
   assign t2m    = tv_ff[idx_ff] ? t2_rd : '0;
   assign t3m    = tv_ff[idx_ff] ? t3_rd : '0;
   // add one to a negative value, then shift arithmetically: truncates toward zero
   assign half_s = $unsigned($signed(sum_ff + TS_W'(sum_ff[TS_W-1])) >>> 1);
   assign half_d = $unsigned($signed(dif_ff + TS_W'(dif_ff[TS_W-1])) >>> 1);
   assign val_rd = sel_ff ? off_rd : del_rd;
   assign mag    = ($signed(a_ff) >= $signed(val_rd)) ? (a_ff - val_rd) : (val_rd - a_ff);

   // round bookkeeping for a response
   always_comb begin
      tally_in = tally_ff + CNT_W'(1);
      meas_in  = meas_ff + (flag_ff[idx_ff] ? CW'(0) : CW'(1));
      round_go = tally_in >= srv_cnt_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               state_in = (req_kind == KIND_SYNC) ? ST_DONE : ST_R_RD;
            end
         end
         ST_R_RD:   state_in = ST_R_SUM;
         ST_R_SUM:  state_in = ST_R_HALF;
         ST_R_HALF: begin
            state_in = (round_go && 32'(meas_in) > FAULT_LIMIT) ? ST_A_I : ST_DONE;
         end
         ST_A_I:     state_in = flag_ff[i_ff] ? ST_A_IWAIT : ST_A_INEXT;
         ST_A_IWAIT: state_in = ST_A_J;
         ST_A_J: begin
            if (flag_ff[j_ff]) begin
               state_in = ST_A_JWAIT;
            end else if (j_ff == LAST_IDX) begin
               state_in = ST_A_SCW;
            end
         end
         ST_A_JWAIT: state_in = ST_A_SQ;
         ST_A_SQ: begin
            if (!sq_busy) begin
               state_in = (j_ff == LAST_IDX) ? ST_A_SCW : ST_A_J;
            end
         end
         ST_A_SCW:   state_in = ST_A_INEXT;
         ST_A_INEXT: state_in = (i_ff == LAST_IDX) ? ST_P_INIT : ST_A_I;
         ST_P_INIT:  state_in = ST_P_START;
         ST_P_START: state_in = ST_P_SCAN;
         ST_P_SCAN:  state_in = ST_P_CMP;
         ST_P_CMP:   state_in = (m_ff == LAST_IDX) ? ST_P_PICK : ST_P_SCAN;
         ST_P_PICK:  state_in = ST_P_PWAIT;
         ST_P_PWAIT: state_in = ST_P_DIV;
         ST_P_DIV: begin
            if (div_done) begin
               state_in = (k_ff == KW'(FAULT_LIMIT)) ? ST_P_END : ST_P_START;
            end
         end
         ST_P_END: state_in = sel_ff ? ST_DONE : ST_A_I;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      ts_we        = accept && in_range && req_kind == KIND_SYNC;
      val_we       = state_ff == ST_R_HALF;
      sc_we        = state_ff == ST_A_SCW;
      div_start    = state_ff == ST_P_PWAIT;
      sq_ctl.start = state_ff == ST_A_JWAIT;
      sq_ctl.clear = state_ff == ST_A_IWAIT;
      unique case (state_ff)
         ST_A_J:    val_raddr = j_ff;
         ST_P_PICK: val_raddr = best_ff;
         default:   val_raddr = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         srv_cnt_ff   <= CNT_RESET;
         tally_ff     <= '0;
         tv_ff        <= '0;
         flag_ff      <= '0;
         meas_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            srv_cnt_ff <= csr_write_data;
         end
         if (ts_we) begin
            tv_ff[req_idx] <= 1'b1;
         end
         if (state_ff == ST_R_HALF) begin
            flag_ff[idx_ff] <= 1'b1;
            meas_ff         <= meas_in;
            tally_ff        <= round_go ? '0 : tally_in;
         end
         if (state_ff == ST_DONE && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            kind_ff   <= req_kind;
            sidx_ff   <= req_server_index;
            idx_ff    <= req_idx;
            remote_ff <= req_remote_time;
            t2_ff     <= req_arrival_time;
            t3_ff     <= req_departure_time;
            aggv_ff   <= 1'b0;
            aggd_ff   <= '0;
            aggo_ff   <= '0;
         end
         ST_R_RD: begin
            down_ff <= t2m - t1m;
            up_ff   <= remote_ff - t3m;
         end
         ST_R_SUM: begin
            sum_ff <= down_ff + up_ff;
            dif_ff <= down_ff - up_ff;
         end
         ST_R_HALF: begin
            delay_ff  <= half_s;
            offset_ff <= half_d;
            aggv_ff   <= round_go && 32'(meas_in) > FAULT_LIMIT;
            sel_ff    <= 1'b0;
            i_ff      <= '0;
         end
         ST_A_IWAIT: begin
            a_ff <= val_rd;
            j_ff <= '0;
         end
         ST_A_J: begin
            if (!flag_ff[j_ff] && j_ff != LAST_IDX) begin
               j_ff <= j_ff + IW'(1);
            end
         end
         ST_A_SQ: begin
            if (!sq_busy && j_ff != LAST_IDX) begin
               j_ff <= j_ff + IW'(1);
            end
         end
         ST_A_INEXT: begin
            if (i_ff != LAST_IDX) begin
               i_ff <= i_ff + IW'(1);
            end
         end
         ST_P_INIT: begin
            picked_ff  <= '0;
            k_ff       <= '0;
            acc_sum_ff <= '0;
         end
         ST_P_START: begin
            found_ff <= 1'b0;
            m_ff     <= '0;
         end
         ST_P_CMP: begin
            // strict less keeps the lower id on a tie
            if (flag_ff[m_ff] && !picked_ff[m_ff] && (!found_ff || sc_rd < best_sc_ff)) begin
               found_ff   <= 1'b1;
               best_ff    <= m_ff;
               best_sc_ff <= sc_rd;
            end
            if (m_ff != LAST_IDX) begin
               m_ff <= m_ff + IW'(1);
            end
         end
         ST_P_PICK: picked_ff[best_ff] <= 1'b1;
         ST_P_DIV: begin
            if (div_done) begin
               acc_sum_ff <= acc_sum_ff + quot;
               k_ff       <= k_ff + KW'(1);
            end
         end
         ST_P_END: begin
            if (sel_ff) begin
               aggo_ff <= acc_sum_ff;
            end else begin
               aggd_ff <= acc_sum_ff;
               sel_ff  <= 1'b1;
               i_ff    <= '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               o_kind_ff <= (kind_ff == KIND_SYNC) ? RES_REQ : RES_MEAS;
               o_srv_ff  <= sidx_ff;
               o_send_ff <= (kind_ff == KIND_SYNC) ? t3_ff : '0;
               o_echo_ff <= (kind_ff == KIND_SYNC) ? t2_ff : '0;
               o_del_ff  <= (kind_ff == KIND_SYNC) ? '0 : delay_ff;
               o_off_ff  <= (kind_ff == KIND_SYNC) ? '0 : offset_ff;
               o_aggv_ff <= (kind_ff == KIND_SYNC) ? 1'b0 : aggv_ff;
               o_aggd_ff <= (kind_ff == KIND_SYNC) ? '0 : aggd_ff;
               o_aggo_ff <= (kind_ff == KIND_SYNC) ? '0 : aggo_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = o_kind_ff;
   assign rsp_server_out       = o_srv_ff;
   assign rsp_request_send_time = o_send_ff;
   assign rsp_request_echo_time = o_echo_ff;
   assign rsp_path_delay       = o_del_ff;
   assign rsp_clock_offset     = o_off_ff;
   assign rsp_aggregate_valid  = o_aggv_ff;
   assign rsp_aggregate_delay  = o_aggd_ff;
   assign rsp_aggregate_offset = o_aggo_ff;

`ifndef NO_ASSERTIONS
   a_sq_no_overlap: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.start |-> !sq_busy) else $error("square unit restarted while busy");
   a_meas_count: assert property (@(posedge clock) disable iff (reset)
      32'(meas_ff) == $countones(flag_ff)) else $error("measured count out of step");
   a_agg_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_aggregate_valid |-> rsp_result_kind == RES_MEAS)
      else $error("aggregate on a delay request");
`endif

endmodule

[rtl/psoa_ram.sv]
// generic single write, single read memory with registered read data
// no dependencies
module psoa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/psoa_sqacc.sv]
// square-and-accumulate unit: adds the exact square of a 64-bit magnitude
// to a wide score using one 32x32 multiplier over three products
// depends on psoa_pkg
module psoa_sqacc import psoa_pkg::*; #(
   parameter int SCORE_W = 2 * TS_W + 4
) (
   input  logic               clock,
   input  logic               reset,
   input  sq_ctl_type         ctl,
   input  logic [TS_W-1:0]    mag,
   output logic               busy,
   output logic [SCORE_W-1:0] acc
);

   logic [31:0]        xl_ff, xh_ff;
   sq_step_type        step_ff, step_in;
   logic               issue_ff, issue_in;
   logic [63:0]        prod_ff, prod_in;
   sq_step_type        pstep_ff;
   logic               pv_ff;
   logic [SCORE_W-1:0] acc_ff, acc_in, addend;
   logic [31:0]        ma, mb;

   always_comb begin
      unique case (step_ff)
         SQ_LL:   begin ma = xl_ff; mb = xl_ff; end
         SQ_LH:   begin ma = xl_ff; mb = xh_ff; end
         SQ_HH:   begin ma = xh_ff; mb = xh_ff; end
         default: begin ma = '0;    mb = '0;    end
      endcase
      prod_in = 64'(ma) * 64'(mb);
      step_in = step_ff;
      issue_in = issue_ff;
      if (ctl.start) begin
         step_in  = SQ_LL;
         issue_in = 1'b1;
      end else if (issue_ff) begin
         unique case (step_ff)
            SQ_LL:   step_in = SQ_LH;
            SQ_LH:   step_in = SQ_HH;
            default: issue_in = 1'b0;
         endcase
      end
      // cross term counts twice, hence the extra shift bit
      unique case (pstep_ff)
         SQ_LL:   addend = SCORE_W'(prod_ff);
         SQ_LH:   addend = SCORE_W'(prod_ff) << 33;
         SQ_HH:   addend = SCORE_W'(prod_ff) << 64;
         default: addend = '0;
      endcase
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pv_ff    <= 1'b0;
         step_ff  <= SQ_LL;
      end else begin
         issue_ff <= issue_in;
         pv_ff    <= issue_ff;
         step_ff  <= step_in;
      end
      if (ctl.start) begin
         xl_ff <= mag[31:0];
         xh_ff <= mag[63:32];
      end
      prod_ff  <= prod_in;
      pstep_ff <= step_ff;
      acc_ff   <= acc_in;
   end

   assign busy = issue_ff | pv_ff;
   assign acc  = acc_ff;

endmodule

[rtl/psoa_cdiv.sv]
// signed divide by a constant, truncating toward zero: eight restoring
// compare-and-subtract steps per cycle over the 64-bit value; depends on psoa_pkg
module psoa_cdiv import psoa_pkg::*; #(
   parameter int DIVISOR = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [TS_W-1:0] value,
   output logic            done,
   output logic [TS_W-1:0] quot
);

   localparam int RW    = $clog2(DIVISOR) + 1;
   localparam int BPC   = 8;
   localparam int STEPS = TS_W / BPC;
   localparam int CNTW  = $clog2(STEPS);

   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [TS_W-1:0] work_ff, work_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic            neg_ff;
   logic [RW:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = value[TS_W-1] ? (TS_W'(0) - value) : value;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int b = 0; b < BPC; b++) begin
            trial = {rem_in, work_in[TS_W-1]};
            if (trial >= (RW+1)'(DIVISOR)) begin
               rem_in  = RW'(trial - (RW+1)'(DIVISOR));
               work_in = {work_in[TS_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[RW-1:0];
               work_in = {work_in[TS_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (start) begin
         neg_ff <= value[TS_W-1];
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? (TS_W'(0) - work_ff) : work_ff;

endmodule

[tb/ptp_multi_server_offset_aggregator_top_tb.sv]
// testbench of the multi-server offset aggregator: directed table, then random
// sync / delay-response beats checked against an in-bench predictor
// depends on psoa_pkg and ptp_multi_server_offset_aggregator_top
module ptp_multi_server_offset_aggregator_top_tb;
   import psoa_pkg::*;

   localparam int NSRV      = DEF_MAX_SERVERS;
   localparam int NPICK     = DEF_FAULT_LIMIT + 1;
   localparam int WDOG_MAX  = 40000;
   localparam logic [63:0] ONES = {64{1'b1}};
   localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;

   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] srv;
      logic [TS_W-1:0]  remote;
      logic [TS_W-1:0]  arrival;
      logic [TS_W-1:0]  departure;
   } msg_type;

   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] srv;
      logic [TS_W-1:0]  send_t;
      logic [TS_W-1:0]  echo_t;
      logic [TS_W-1:0]  delay;
      logic [TS_W-1:0]  offset;
      logic             agg_ok;
      logic [TS_W-1:0]  agg_delay;
      logic [TS_W-1:0]  agg_offset;
   } meas_type;

   typedef struct {
      msg_type  m;
      logic     typed;
      meas_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [IDX_W-1:0] req_server_index = '0;
   logic [TS_W-1:0] req_remote_time = '0;
   logic [TS_W-1:0] req_arrival_time = '0;
   logic [TS_W-1:0] req_departure_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   logic rsp_result_kind;
   logic [IDX_W-1:0] rsp_server_out;
   logic [TS_W-1:0] rsp_request_send_time, rsp_request_echo_time;
   logic signed [TS_W-1:0] rsp_path_delay, rsp_clock_offset;
   logic rsp_aggregate_valid;
   logic signed [TS_W-1:0] rsp_aggregate_delay, rsp_aggregate_offset;

   ptp_multi_server_offset_aggregator_top DUT (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_kind, .req_server_index, .req_remote_time,
      .req_arrival_time, .req_departure_time,
      .rsp_valid, .rsp_ready, .rsp_result_kind, .rsp_server_out,
      .rsp_request_send_time, .rsp_request_echo_time, .rsp_path_delay,
      .rsp_clock_offset, .rsp_aggregate_valid, .rsp_aggregate_delay,
      .rsp_aggregate_offset
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [63:0] t1_mem [NSRV];
   logic [63:0] t2_mem [NSRV];
   logic [63:0] t3_mem [NSRV];
   logic [63:0] delay_mem [NSRV];
   logic [63:0] offset_mem [NSRV];
   bit          measured [NSRV];
   logic [CNT_W-1:0] tally;
   logic [CNT_W-1:0] round_len;

   meas_type pending_meas [$];
   bit    failed = 0;
   bit    stall_on = 1;
   int    idle_run = 0;

   function automatic logic [63:0] half_trunc(logic [63:0] v, int unsigned d);
      logic [63:0] mag, q;
      mag = v[63] ? -v : v;
      q = mag / d;
      return v[63] ? -q : q;
   endfunction

   function automatic logic [63:0] fault_tolerant_mean(bit use_offset);
      bit [135:0] score [NSRV];
      bit picked [NSRV];
      logic [63:0] a, b, d, sum;
      int best;
      sum = '0;
      for (int i = 0; i < NSRV; i++) begin
         score[i] = '0;
         picked[i] = 0;
         if (!measured[i]) continue;
         for (int j = 0; j < NSRV; j++) begin
            if (!measured[j]) continue;
            a = use_offset ? offset_mem[i] : delay_mem[i];
            b = use_offset ? offset_mem[j] : delay_mem[j];
            d = ($signed(a) >= $signed(b)) ? a - b : b - a;
            score[i] += {72'b0, d} * {72'b0, d};
         end
      end
      for (int k = 0; k < NPICK; k++) begin
         best = -1;
         for (int i = 0; i < NSRV; i++) begin
            if (!measured[i] || picked[i]) continue;
            if (best < 0 || score[i] < score[best]) best = i;
         end
         if (best < 0) break;
         picked[best] = 1;
         a = use_offset ? offset_mem[best] : delay_mem[best];
         sum += half_trunc(a, NPICK);
      end
      return sum;
   endfunction

   function automatic meas_type predict_meas(msg_type m);
      meas_type r;
      int s, cnt;
      logic [63:0] down, up;
      s = m.srv;
      r = '{default: '0};
      r.srv = m.srv;
      if (m.kind == KIND_SYNC) begin
         t1_mem[s] = m.remote;
         t2_mem[s] = m.arrival;
         t3_mem[s] = m.departure;
         r.kind = RES_REQ;
         r.send_t = m.departure;
         r.echo_t = m.arrival;
         return r;
      end
      down = t2_mem[s] - t1_mem[s];
      up = m.remote - t3_mem[s];
      r.kind = RES_MEAS;
      r.delay = half_trunc(down + up, 2);
      r.offset = half_trunc(down - up, 2);
      delay_mem[s] = r.delay;
      offset_mem[s] = r.offset;
      measured[s] = 1;
      tally = tally + 1'b1;
      if (tally >= round_len) begin
         tally = '0;
         cnt = 0;
         for (int n = 0; n < NSRV; n++) if (measured[n]) cnt++;
         if (cnt > DEF_FAULT_LIMIT) begin
            r.agg_ok = 1'b1;
            r.agg_delay = fault_tolerant_mean(0);
            r.agg_offset = fault_tolerant_mean(1);
         end
      end
      return r;
   endfunction

   // receiver stalls in bursts
   int rsp_hold = 0;
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
         rsp_hold <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      meas_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_meas.size() == 0) begin
            $error("result beat with no expectation");
            failed = 1;
         end else begin
            w = pending_meas.pop_front();
            check_field("result_kind", w.kind, rsp_result_kind);
            check_field("server_out", w.srv, rsp_server_out);
            check_field("request_send_time", w.send_t, rsp_request_send_time);
            check_field("request_echo_time", w.echo_t, rsp_request_echo_time);
            check_field("path_delay", w.delay, rsp_path_delay);
            check_field("clock_offset", w.offset, rsp_clock_offset);
            check_field("aggregate_valid", w.agg_ok, rsp_aggregate_valid);
            check_field("aggregate_delay", w.agg_delay, rsp_aggregate_delay);
            check_field("aggregate_offset", w.agg_offset, rsp_aggregate_offset);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_run <= 0;
         else idle_run <= idle_run + 1;
         if (idle_run > WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_msg(msg_type m, bit typed, meas_type want);
      meas_type p;
      req_valid <= 1'b1;
      req_kind <= m.kind;
      req_server_index <= m.srv;
      req_remote_time <= m.remote;
      req_arrival_time <= m.arrival;
      req_departure_time <= m.departure;
      do @(posedge clock); while (!req_ready);
      p = predict_meas(m);
      pending_meas.push_back(typed ? want : p);
   endtask

   task automatic pause_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (stall_on && $urandom_range(0, 3) == 0) pause_req($urandom_range(1, 14));
   endtask

   task automatic drain_and_config(logic [CNT_W-1:0] v);
      pause_req(1);
      while (pending_meas.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      round_len = v;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random beats: mostly sync followed by its response, some noise
   bit          have_sync = 0;
   logic [3:0]  sync_srv;
   logic [63:0] sync_t3, sync_off;

   function automatic msg_type next_random_msg();
      msg_type m;
      logic [63:0] t1, t2;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         m.kind = $urandom_range(0, 1);
         m.srv = $urandom_range(0, NSRV - 1);
         m.remote = rand64();
         m.arrival = rand64();
         m.departure = rand64();
      end else if (have_sync && pick < 80) begin
         m.kind = KIND_RESP;
         m.srv = sync_srv;
         m.remote = sync_t3 + $urandom_range(0, 5000) - sync_off;
         m.arrival = rand64();
         m.departure = rand64();
         have_sync = 0;
      end else begin
         t1 = rand64();
         sync_off = {{44{1'b0}}, 20'($urandom)} - 64'd524288;
         t2 = t1 + $urandom_range(0, 5000) + sync_off;
         m.kind = KIND_SYNC;
         m.srv = $urandom_range(0, NSRV - 1);
         m.remote = t1;
         m.arrival = t2;
         m.departure = t2 + $urandom_range(0, 10000);
         sync_srv = m.srv;
         sync_t3 = m.departure;
         have_sync = 1;
      end
      return m;
   endfunction

   row_type dir_rows [$];

   function automatic void add_row(logic k, logic [3:0] s, logic [63:0] r,
                                   logic [63:0] a, logic [63:0] d);
      row_type x;
      x.m = '{k, s, r, a, d};
      x.typed = 0;
      x.want = '{default: '0};
      dir_rows.push_back(x);
   endfunction

   initial begin
      row_type x;
      meas_type none;
      logic [CNT_W-1:0] lens [8];
      int counts [8];
      none = '{default: '0};
      for (int i = 0; i < NSRV; i++) begin
         t1_mem[i] = '0; t2_mem[i] = '0; t3_mem[i] = '0;
         delay_mem[i] = '0; offset_mem[i] = '0; measured[i] = 0;
      end
      tally = '0;
      round_len = CNT_RESET;

      // response with no sync after reset: stored times are zero
      x.m = '{KIND_RESP, 4'd0, 64'd100, '0, '0};
      x.typed = 1;
      x.want = '{RES_MEAS, 4'd0, '0, '0, 64'd50, -64'sd50, 1'b0, '0, '0};
      dir_rows.push_back(x);
      add_row(KIND_RESP, 0, 0, 0, 0);
      add_row(KIND_RESP, 0, ONES, 0, 0);
      // round closes with one measured server only
      add_row(KIND_RESP, 0, MSB, 0, 0);
      x.m = '{KIND_SYNC, 4'd15, ONES, ONES, '0};
      x.typed = 1;
      x.want = '{RES_REQ, 4'd15, '0, ONES, '0, '0, 1'b0, '0, '0};
      dir_rows.push_back(x);
      add_row(KIND_SYNC, 0, 0, 1000, 2000);
      add_row(KIND_RESP, 0, 4000, 0, 0);
      add_row(KIND_SYNC, 1, ONES, 0, ONES);
      add_row(KIND_RESP, 1, 0, ONES, ONES);
      add_row(KIND_SYNC, 2, MSB, MSB - 1, 5);
      add_row(KIND_RESP, 2, ONES, 0, 0);
      add_row(KIND_RESP, 15, MSB - 1, 0, 0);
      add_row(KIND_SYNC, 7, {16{4'h5}}, {16{4'ha}}, {16{4'h5}});
      add_row(KIND_RESP, 7, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
      add_row(KIND_RESP, 8, 1, 0, 0);
      add_row(KIND_SYNC, 9, 100, 90, 95);
      add_row(KIND_RESP, 9, 103, 0, 0);
      add_row(KIND_RESP, 2, MSB, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_msg(dir_rows[i].m, dir_rows[i].typed, dir_rows[i].want);
         maybe_gap();
      end

      lens = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd4, 5'd7, 5'd12, 5'd4};
      counts = '{40, 24, 260, 180, 300, 200, 180, 150};
      for (int p = 0; p < 8; p++) begin
         if (p == 7) stall_on = 0;
         drain_and_config(lens[p]);
         for (int n = 0; n < counts[p]; n++) begin
            send_msg(next_random_msg(), 0, none);
            maybe_gap();
         end
      end

      pause_req(1);
      while (pending_meas.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed && pending_meas.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/psoa_pkg.sv
rtl/psoa_ram.sv
rtl/psoa_sqacc.sv
rtl/psoa_cdiv.sv
rtl/ptp_multi_server_offset_aggregator_top.sv
tb/ptp_multi_server_offset_aggregator_top_tb.sv
